@@ rtl/bda_pkg.sv @@
package bda_pkg;

  // Default width of the binary value that is converted.
  localparam int unsigned VALUE_BITS_DEFAULT = 64;

  // Width of the value field on the input channel.
  localparam int unsigned VALUE_W = 64;

  // Width of the character field on the output channel.
  localparam int unsigned CHAR_W = 6;

  // One BCD digit.
  localparam int unsigned DIGIT_W = 4;

  // ASCII code of the character '0'.
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Double-dabble correction: a digit of five or more gets three added before the shift.
  localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

endpackage

@@ rtl/bda_stream_if.sv @@
// Input channel: one binary value per transfer.
interface bda_value_if;
  logic                              valid;
  logic                              ready;
  logic [bda_pkg::VALUE_W-1:0]       value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// Output channel: one ASCII digit per transfer.
interface bda_digit_if;
  logic                              valid;
  logic                              ready;
  logic [bda_pkg::CHAR_W-1:0]        digit_char;
  logic                              last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink (input valid, input digit_char, input last, output ready);
endinterface

@@ rtl/bda_front.sv @@
module bda_front #(
  parameter int unsigned VALUE_BITS = bda_pkg::VALUE_BITS_DEFAULT,
  parameter int unsigned NUM_DIGITS = 20,
  parameter int unsigned IDX_W      = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  bda_value_if.sink                           value_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output logic [NUM_DIGITS*bda_pkg::DIGIT_W-1:0] push_bcd_o,
  output logic [IDX_W-1:0]                    push_top_o
);
  import bda_pkg::*;

  localparam int unsigned BcdW = NUM_DIGITS * DIGIT_W;
  localparam int unsigned CntW = $clog2(VALUE_BITS);

  localparam logic [1:0] FS_IDLE  = 2'd0;
  localparam logic [1:0] FS_SHIFT = 2'd1;
  localparam logic [1:0] FS_PUSH  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic [BcdW-1:0]       bcd_adj;
  logic [IDX_W-1:0]      top_idx;
  logic                  in_xfer;

  assign value_i.ready = (state_q == FS_IDLE);
  assign in_xfer       = value_i.valid && value_i.ready;

  // Add-three correction on every digit, all digits in parallel.
  always_comb begin
    logic [DIGIT_W-1:0] dig;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig = bcd_q[i*DIGIT_W +: DIGIT_W];
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (dig >= DABBLE_MIN) ? dig + DABBLE_ADD : dig;
    end
  end

  // Position of the most significant nonzero digit; zero maps to the lowest digit.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign push_valid_o = (state_q == FS_PUSH);
  assign push_bcd_o   = bcd_q;
  assign push_top_o   = top_idx;

  // Sequencer: load, one shift per value bit, then hand the digits to the queue.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    bcd_d   = bcd_q;
    unique case (state_q)
      FS_IDLE: begin
        if (in_xfer) begin
          val_d   = value_i.value[VALUE_BITS-1:0];
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = FS_SHIFT;
        end
      end
      FS_SHIFT: begin
        bcd_d = {bcd_adj[BcdW-2:0], val_q[VALUE_BITS-1]};
        val_d = {val_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(VALUE_BITS - 1)) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (push_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    bcd_q <= bcd_d;
  end

endmodule

@@ rtl/bda_fifo.sv @@
module bda_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  // Two entries let the front finish the next value while the back still emits.
  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/bda_back.sv @@
module bda_back #(
  parameter int unsigned NUM_DIGITS = 20,
  parameter int unsigned IDX_W      = 5
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   pop_valid_i,
  output logic                                   pop_ready_o,
  input  logic [NUM_DIGITS*bda_pkg::DIGIT_W-1:0] pop_bcd_i,
  input  logic [IDX_W-1:0]                       pop_top_i,
  bda_digit_if.source                            digit_o
);
  import bda_pkg::*;

  localparam int unsigned BcdW = NUM_DIGITS * DIGIT_W;

  logic               busy_q;
  logic [IDX_W-1:0]   idx_q;
  logic [BcdW-1:0]    bcd_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;
  logic               out_free, emit, load;
  logic [DIGIT_W-1:0] cur_digit;

  assign out_free    = !out_valid_q || digit_o.ready;
  assign emit        = busy_q && out_free;
  assign pop_ready_o = !busy_q;
  assign load        = pop_valid_i && pop_ready_o;
  assign cur_digit   = bcd_q[{idx_q, 2'b00} +: DIGIT_W];

  assign digit_o.valid      = out_valid_q;
  assign digit_o.digit_char = char_q;
  assign digit_o.last       = last_q;

  // Walk from the leading digit down to digit zero, one per cycle while the output is not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= pop_top_i;
      end else if (emit) begin
        if (idx_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q - 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (digit_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Digit store and output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q <= pop_bcd_i;
    end
    if (emit) begin
      char_q <= ASCII_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, cur_digit};
      last_q <= (idx_q == '0);
    end
  end

endmodule

@@ rtl/binary_to_decimal_ascii_core.sv @@
// Converts an unsigned binary value (the low VALUE_BITS bits of each input
// transfer) into its decimal text, one ASCII digit per output transfer, most
// significant digit first, no leading zeros, with last set on the final digit;
// zero gives the single digit '0'. The front converts by bit-serial double
// dabble: it accepts a value, shifts once per value bit and then hands the
// digits to a two-entry queue, which separates it from the back; the back
// emits one digit per cycle while the receiver takes them, so the front can
// convert the next value while the back still emits the last one.
module binary_to_decimal_ascii_core #(
  parameter int unsigned VALUE_BITS = bda_pkg::VALUE_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bda_value_if.sink   value_i,
  bda_digit_if.source digit_o
);
  import bda_pkg::*;

  // Decimal digits of 2^VALUE_BITS - 1, from log10(2) ~ 0.30103.
  localparam int unsigned NumDigits = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned IdxW      = $clog2(NumDigits);
  localparam int unsigned BcdW      = NumDigits * DIGIT_W;
  localparam int unsigned EntryW    = BcdW + IdxW;

  logic             push_valid, push_ready;
  logic [BcdW-1:0]  push_bcd;
  logic [IdxW-1:0]  push_top;
  logic             pop_valid, pop_ready;
  logic [EntryW-1:0] pop_data;

  bda_front #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NumDigits),
    .IDX_W      (IdxW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_bcd_o   (push_bcd),
    .push_top_o   (push_top)
  );

  bda_fifo #(
    .WIDTH (EntryW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_bcd, push_top}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  bda_back #(
    .NUM_DIGITS (NumDigits),
    .IDX_W      (IdxW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_bcd_i   (pop_data[EntryW-1:IdxW]),
    .pop_top_i   (pop_data[IdxW-1:0]),
    .digit_o     (digit_o)
  );

endmodule

@@ tb/sv/tb_binary_to_decimal_ascii_core.sv @@
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_core;
  import bda_pkg::*;

  localparam int unsigned VALUE_BITS   = VALUE_BITS_DEFAULT;
  localparam int unsigned MAX_DIGITS   = 20;
  localparam int unsigned MAX_WAIT     = 13;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = VALUE_BITS + 2 * MAX_DIGITS;
  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);
  localparam logic [VALUE_W-1:0] RADIX = 64'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } digit_t;

  logic clk_i;
  logic rst_ni;

  bda_value_if value_if ();
  bda_digit_if digit_if ();

  binary_to_decimal_ascii_core #(
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (value_if),
    .digit_o (digit_if)
  );

  // Digits still owed by the block, oldest first.
  digit_t          expected_digits[$];
  int unsigned     error_count    = 0;
  int unsigned     values_sent    = 0;
  int unsigned     digits_checked = 0;
  bit              idle_on        = 1'b1;
  bit [MAX_DIGITS:1] lengths_seen = '0;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Appends the decimal digits of one value, most significant first, and
  // returns how many there are.
  function automatic int unsigned queue_decimal_digits(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] rest;
    logic [DIGIT_W-1:0] digits[MAX_DIGITS];
    int unsigned        count;
    digit_t             d;
    rest  = value & VALUE_MASK;
    count = 0;
    do begin
      digits[count] = DIGIT_W'(rest % RADIX);
      rest          = rest / RADIX;
      count++;
    end while (rest != 0 && count < MAX_DIGITS);
    for (int k = count; k > 0; k--) begin
      d.digit_char = ASCII_ZERO + CHAR_W'(digits[k-1]);
      d.last       = (k == 1);
      expected_digits.push_back(d);
    end
    return count;
  endfunction

  // Offers one value after a random gap and waits for its transfer. Valid
  // stays high afterwards so that a zero gap gives back-to-back transfers.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int unsigned gap;
    int unsigned count;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap != 0) begin
      value_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    value_if.valid <= 1'b1;
    value_if.value <= value;
    do @(posedge clk_i); while (!value_if.ready);
    count = queue_decimal_digits(value);
    lengths_seen[count] = 1'b1;
    values_sent++;
  endtask

  function automatic logic [VALUE_W-1:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // Random value whose bit length is itself random, so every digit count occurs.
  function automatic logic [VALUE_W-1:0] random_sized_value();
    int unsigned bits;
    bits = $urandom_range(1, VALUE_W);
    return random_word() >> (VALUE_W - bits);
  endfunction

  // Extremes, decade edges, the ten-digit region and alternating bit patterns.
  task automatic test_directed_values();
    logic [VALUE_W-1:0] values[$] = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
      64'd4294967295, 64'd4294967296, 64'd999999999, 64'd1000000000,
      64'd9999999999, 64'd12345678901234567890,
      64'd9999999999999999999, 64'd10000000000000000000,
      64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF
    };
    foreach (values[i]) send_value(values[i]);
  endtask

  // Random values of every bit length, with both sides idling at random.
  task automatic test_random_lengths(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) send_value(random_word());
      else send_value(random_sized_value());
    end
  endtask

  // Values just below, at and just above a power of ten.
  task automatic test_decade_boundaries(input int unsigned count);
    logic [VALUE_W-1:0] power;
    int unsigned        exponent;
    repeat (count) begin
      exponent = $urandom_range(1, MAX_DIGITS - 1);
      power    = 64'd1;
      repeat (exponent) power = power * RADIX;
      case ($urandom_range(0, 2))
        0:       send_value(power - 64'd1);
        1:       send_value(power);
        default: send_value(power + VALUE_W'($urandom_range(1, 999)));
      endcase
    end
  endtask

  // Back-to-back values and a receiver that never stalls.
  task automatic test_streaming_no_idle(input int unsigned count);
    idle_on = 1'b0;
    repeat (count) send_value(random_sized_value());
    idle_on = 1'b1;
  endtask

  // Receiver: when idling is on, stalls a random number of cycles before each digit transfer.
  initial begin
    int unsigned stall;
    digit_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall != 0) begin
        digit_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      digit_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(digit_if.valid && digit_if.ready));
    end
  end

  // Compares each digit transfer with the oldest expected digit.
  always @(posedge clk_i) begin
    digit_t want;
    if (rst_ni && digit_if.valid && digit_if.ready) begin
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit 0x%0h last=%0b",
                                  digit_if.digit_char, digit_if.last));
      end else begin
        want = expected_digits.pop_front();
        digits_checked++;
        if (digit_if.digit_char !== want.digit_char)
          report_mismatch($sformatf("digit_char got 0x%0h, want 0x%0h",
                                    digit_if.digit_char, want.digit_char));
        if (digit_if.last !== want.last)
          report_mismatch($sformatf("last got %0b, want %0b on digit 0x%0h",
                                    digit_if.last, want.last, want.digit_char));
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    wait (rst_ni);
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((value_if.valid && value_if.ready) || (digit_if.valid && digit_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[%0t] timeout with %0d digits outstanding", $time, expected_digits.size());
    $display("binary_to_decimal_ascii_core test failed");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni         <= 1'b0;
    value_if.valid <= 1'b0;
    value_if.value <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_values();
    test_random_lengths(150);
    test_decade_boundaries(60);
    test_streaming_no_idle(90);
    value_if.valid <= 1'b0;

    // Let every owed digit arrive, then watch for stray ones.
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_digits.size() != 0)
      report_mismatch($sformatf("%0d digits never arrived", expected_digits.size()));

    $display("Converted %0d values into %0d checked digits, %0d of %0d run lengths seen,",
             values_sent, digits_checked, $countones(lengths_seen), MAX_DIGITS);
    $display("with random idling on both channels and a back-to-back phase; %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("binary_to_decimal_ascii_core test passed");
    end else begin
      $display("binary_to_decimal_ascii_core test failed");
    end
    $finish;
  end

endmodule
